>>> design/u16u8_pkg.sv
`default_nettype none

package u16u8_pkg;

	localparam logic [15:0] BOM_NATIVE  = 16'hfeff;
	localparam logic [15:0] BOM_SWAPPED = 16'hfffe;

	localparam logic [1:0] LEN_NONE = 2'd0;
	localparam logic [1:0] LEN_ONE  = 2'd1;
	localparam logic [1:0] LEN_TWO  = 2'd2;
	localparam logic [1:0] LEN_THREE = 2'd3;

	typedef struct packed {
		logic [1:0] len;
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
	} enc_t;

endpackage

`default_nettype wire

>>> design/u16u8_enc.sv
`default_nettype none

module u16u8_enc (
	input  wire logic [15:0]     unit,
	output u16u8_pkg::enc_t      enc
);
	import u16u8_pkg::*;

	always_comb begin
		enc = '0;
		priority if (unit == BOM_NATIVE || unit == BOM_SWAPPED) begin
			enc.len = LEN_NONE;
		end else if (unit[15:7] == 9'd0) begin
			enc.len = LEN_ONE;
			enc.b0  = {1'b0, unit[6:0]};
		end else if (unit[15:11] == 5'd0) begin
			enc.len = LEN_TWO;
			enc.b0  = {3'b110, unit[10:6]};
			enc.b1  = {2'b10, unit[5:0]};
		end else begin
			enc.len = LEN_THREE;
			enc.b0  = {4'b1110, unit[15:12]};
			enc.b1  = {2'b10, unit[11:6]};
			enc.b2  = {2'b10, unit[5:0]};
		end
	end

endmodule

`default_nettype wire

>>> design/utf16_to_utf8_transcoder_top.sv
// Timing: the second byte of a pair is encoded in its transfer cycle; the first UTF-8
//   byte is offered in the next cycle, further bytes one per cycle after it while out_ready is high.
// Flow: one input byte per cycle while in_ready is high; a code unit is two input bytes and
//   yields 0 to 3 output bytes, so the single-byte output port limits the sustained rate.
// Reset (arst_n low, asynchronous): no byte pending, output buffer empty, big endian.
`default_nettype none

module utf16_to_utf8_transcoder_top (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] in_byte,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      out_byte,
	output logic            out_last,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic       big_endian_mode
);
	import u16u8_pkg::*;

	logic        big_endian_q;
	logic        have_q;
	logic [7:0]  first_q;
	logic [1:0]  rem_q;
	logic [7:0]  buf0_q;
	logic [7:0]  buf1_q;
	logic [7:0]  buf2_q;

	logic        buf_free;
	logic        in_xfer;
	logic        out_xfer;
	logic        pair_done;
	logic [15:0] unit;
	enc_t        enc;

	assign cfg_ready = 1'b1;

	assign out_valid = (rem_q != LEN_NONE);
	assign out_byte  = buf0_q;
	assign out_last  = (rem_q == LEN_ONE);
	assign out_xfer  = out_valid && out_ready;

	assign buf_free  = (rem_q == LEN_NONE) || ((rem_q == LEN_ONE) && out_ready);
	assign in_ready  = !have_q || buf_free;
	assign in_xfer   = in_valid && in_ready;
	assign pair_done = in_xfer && have_q;

	assign unit = big_endian_q ? {first_q, in_byte} : {in_byte, first_q};

	u16u8_enc u_enc (
		.unit (unit),
		.enc  (enc)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			big_endian_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			big_endian_q <= big_endian_mode;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q  <= 1'b0;
			first_q <= '0;
		end else if (in_xfer) begin
			have_q <= !have_q;
			if (!have_q) begin
				first_q <= in_byte;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= LEN_NONE;
		end else if (pair_done) begin
			rem_q <= enc.len;
		end else if (out_xfer) begin
			rem_q <= rem_q - 2'd1;
		end
	end

	// byte buffer, loaded on a completed pair, else shifted down on each output transfer
	always_ff @(posedge clk) begin
		if (pair_done) begin
			buf0_q <= enc.b0;
			buf1_q <= enc.b1;
			buf2_q <= enc.b2;
		end else if (out_xfer) begin
			buf0_q <= buf1_q;
			buf1_q <= buf2_q;
		end
	end

endmodule

`default_nettype wire

>>> design/u16u8_chk.sv
`default_nettype none

module u16u8_chk (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [7:0] out_byte,
	input wire logic       out_last
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last))
		else $error("output changed while stalled");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with empty output buffer");

	a_seq_cont: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_last |=> out_valid)
		else $error("multi-byte sequence broken");

	a_out_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready))
		else $error("output appeared without an input transfer");

endmodule

bind utf16_to_utf8_transcoder_top u16u8_chk u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_byte  (out_byte),
	.out_last  (out_last)
);

`default_nettype wire
